// ===== design/rpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and constants of the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int NUM_PAGES_DEF  = 4096;
    localparam int COUNT_BITS_DEF = 16;

    localparam int PAGE_W   = 12;
    localparam int CMD_W    = 3;
    localparam int REFOUT_W = 16;
    localparam int STATUS_W = 3;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT   = 3'd0,
        CMD_ALLOC  = 3'd1,
        CMD_FREE   = 3'd2,
        CMD_ADDREF = 3'd3,
        CMD_GETREF = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 3'd0,
        STS_OOM    = 3'd1,
        STS_RANGE  = 3'd2,
        STS_UNREF  = 3'd3,
        STS_SATUR  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

endpackage : rpa_pkg
`default_nettype wire

// ===== design/rpa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rpa_ram
    import rpa_pkg::*;
#(
    parameter int DEPTH = NUM_PAGES_DEF,
    parameter int WIDTH = COUNT_BITS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule : rpa_ram
`default_nettype wire

// ===== design/refcounted_page_allocator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_page_allocator_top
// Page allocator with a LIFO free stack and a per-page reference count.
//
// Commands enter on the s_ stream (one word per command), one result word
// leaves on the m_ stream for every command. low_page is written through the
// cfg_ channel, which is always ready; write it only while the block is idle.
// Alloc, free, add-ref and get-ref read the count and stack memories at the
// accept edge; in the exec state the block then writes back and loads the
// result register, waiting there while the result register is still full.
// s_tready is high again in the cycle in which the result appears.
// Init sweeps every page once, one page a cycle, clearing its count and
// pushing it when it is at or above low_page; the result follows in exec.
// After reset the block clears the count memory in one pass over all pages
// with s_tready low; cfg writes are taken during the pass.
// The result register holds a word while m_tready is low; the block still
// accepts the next command and waits before loading its result.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_top
    import rpa_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // cfg_data: low_page
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [PAGE_W-1:0]   cfg_data,
    // s_tdata: cmd [2:0], page [14:3], zero [15]
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // m_tdata: alloc_page [11:0], ref_count [27:12], released [28], status [31:29]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam int PAGE_BITS  = $clog2(NUM_PAGES);
    localparam int DEPTH_BITS = PAGE_BITS + 1;
    localparam int PW  = (PAGE_BITS > PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int CMP = PW + 1;
    localparam int CW  = (COUNT_BITS > REFOUT_W) ? COUNT_BITS : REFOUT_W;

    localparam logic [CMP-1:0]        NUM_PAGES_C = CMP'(NUM_PAGES);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX   = DEPTH_BITS'(NUM_PAGES);
    localparam logic [PAGE_BITS-1:0]  LAST_PAGE   = PAGE_BITS'(NUM_PAGES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE   = COUNT_BITS'(1);

    state_t                  state_reg, state_next;
    logic [PAGE_W-1:0]       low_page_reg;
    logic [PAGE_BITS-1:0]    idx_reg, idx_next;
    logic                    push_en_reg, push_en_next;
    logic [DEPTH_BITS-1:0]   depth_reg, depth_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [PAGE_W-1:0]       page_reg, page_next;
    logic                    in_range_reg, in_range_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]     m_tdata_reg, m_tdata_next;

    logic                    s_fire;
    logic                    out_free;
    logic                    exec_go;
    logic [CMD_W-1:0]        s_cmd;
    logic [PAGE_W-1:0]       s_page;
    logic [PW-1:0]           s_page_ext;
    logic [PW-1:0]           page_ext;
    logic [PAGE_BITS-1:0]    page_addr;
    logic [DEPTH_BITS-1:0]   depth_m1;
    logic                    idx_ge_low;

    logic                    cnt_we;
    logic [PAGE_BITS-1:0]    cnt_waddr;
    logic [COUNT_BITS-1:0]   cnt_wdata;
    logic [COUNT_BITS-1:0]   cnt_rd;
    logic                    stk_we;
    logic [PAGE_BITS-1:0]    stk_waddr;
    logic [PAGE_BITS-1:0]    stk_wdata;
    logic [PAGE_BITS-1:0]    stk_rd;

    logic [PAGE_BITS-1:0]    res_page;
    logic [COUNT_BITS-1:0]   res_cnt;
    logic                    res_rel;
    status_t                 res_st;
    logic [PW-1:0]           res_page_ext;
    logic [CW-1:0]           res_cnt_ext;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign s_fire     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign exec_go    = (state_reg == ST_EXEC) && out_free;
    assign s_cmd      = s_tdata[CMD_W-1:0];
    assign s_page     = s_tdata[CMD_W +: PAGE_W];
    assign s_page_ext = PW'(s_page);
    assign page_ext   = PW'(page_reg);
    assign page_addr  = page_ext[PAGE_BITS-1:0];
    assign depth_m1   = depth_reg - DEPTH_BITS'(1);
    assign idx_ge_low = CMP'(idx_reg) >= CMP'(low_page_reg);

    assign res_page_ext = PW'(res_page);
    assign res_cnt_ext  = CW'(res_cnt);

    rpa_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (COUNT_BITS)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (s_fire),
        .raddr (s_page_ext[PAGE_BITS-1:0]),
        .rdata (cnt_rd)
    );

    rpa_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (PAGE_BITS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (s_fire),
        .raddr (depth_m1[PAGE_BITS-1:0]),
        .rdata (stk_rd)
    );

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        push_en_next  = push_en_reg;
        depth_next    = depth_reg;
        cmd_next      = cmd_reg;
        page_next     = page_reg;
        in_range_next = in_range_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        cnt_we    = 1'b0;
        cnt_waddr = page_addr;
        cnt_wdata = '0;
        stk_we    = 1'b0;
        stk_waddr = depth_reg[PAGE_BITS-1:0];
        stk_wdata = page_addr;

        res_page = '0;
        res_cnt  = '0;
        res_rel  = 1'b0;
        res_st   = STS_OK;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cmd_next      = cmd_t'(s_cmd);
                    page_next     = s_page;
                    in_range_next = (CMP'(s_page) >= CMP'(low_page_reg)) &&
                                    (CMP'(s_page) < NUM_PAGES_C);
                    if (cmd_t'(s_cmd) == CMD_INIT) begin
                        state_next   = ST_SWEEP;
                        push_en_next = 1'b1;
                        idx_next     = '0;
                        depth_next   = '0;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_SWEEP: begin
                cnt_we    = 1'b1;
                cnt_waddr = idx_reg;
                if (push_en_reg && idx_ge_low) begin
                    stk_we     = 1'b1;
                    stk_wdata  = idx_reg;
                    depth_next = depth_reg + DEPTH_BITS'(1);
                end
                if (idx_reg == LAST_PAGE) begin
                    state_next = push_en_reg ? ST_EXEC : ST_IDLE;
                end else begin
                    idx_next = idx_reg + PAGE_BITS'(1);
                end
            end
            ST_EXEC: begin
                case (cmd_reg)
                    CMD_INIT: begin
                        res_st = STS_OK;
                    end
                    CMD_ALLOC: begin
                        if (depth_reg == '0) begin
                            res_st = STS_OOM;
                        end else begin
                            cnt_we     = exec_go;
                            cnt_waddr  = stk_rd;
                            cnt_wdata  = COUNT_ONE;
                            depth_next = exec_go ? depth_m1 : depth_reg;
                            res_page   = stk_rd;
                            res_cnt    = COUNT_ONE;
                        end
                    end
                    CMD_FREE: begin
                        if (!in_range_reg) begin
                            res_st = STS_RANGE;
                        end else if (cnt_rd == '0) begin
                            res_st = STS_UNREF;
                        end else if (cnt_rd != COUNT_ONE) begin
                            cnt_we    = exec_go;
                            cnt_wdata = cnt_rd - COUNT_ONE;
                            res_cnt   = cnt_rd - COUNT_ONE;
                        end else begin
                            cnt_we = exec_go;
                            if (depth_reg < DEPTH_MAX) begin
                                stk_we     = exec_go;
                                depth_next = exec_go ? depth_reg + DEPTH_BITS'(1)
                                                     : depth_reg;
                                res_rel    = 1'b1;
                            end
                        end
                    end
                    CMD_ADDREF: begin
                        if (!in_range_reg) begin
                            res_st = STS_RANGE;
                        end else if (cnt_rd == COUNT_MAX) begin
                            res_st  = STS_SATUR;
                            res_cnt = cnt_rd;
                        end else begin
                            cnt_we    = exec_go;
                            cnt_wdata = cnt_rd + COUNT_ONE;
                            res_cnt   = cnt_rd + COUNT_ONE;
                        end
                    end
                    CMD_GETREF: begin
                        if (!in_range_reg) begin
                            res_st = STS_RANGE;
                        end else begin
                            res_cnt = cnt_rd;
                        end
                    end
                    default: begin
                        res_st = STS_OK;
                    end
                endcase
                if (exec_go) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_st, res_rel, res_cnt_ext[REFOUT_W-1:0],
                                     res_page_ext[PAGE_W-1:0]};
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            low_page_reg <= '0;
            idx_reg      <= '0;
            push_en_reg  <= 1'b0;
            depth_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            push_en_reg  <= push_en_next;
            depth_reg    <= depth_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                low_page_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        page_reg     <= page_next;
        in_range_reg <= in_range_next;
        m_tdata_reg  <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_MAX)
        else $error("free stack depth beyond page count");

    a_alloc_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_go && cmd_reg == CMD_ALLOC && depth_reg != '0) |=>
        depth_reg == ($past(depth_reg) - DEPTH_BITS'(1)))
        else $error("alloc did not pop the free stack");

    a_push_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_we |-> (CMP'(stk_wdata) >= CMP'(low_page_reg)))
        else $error("page below low_page pushed onto free stack");
`endif

endmodule : refcounted_page_allocator_top
`default_nettype wire
